// ===== rtl/core/ptt_pkg.sv =====
// Shared types and constants for the periodic task timer bank.
package ptt_pkg;

	localparam int SLOT_BITS = 3;
	localparam int OP_BITS   = 3;

	typedef enum logic [OP_BITS-1:0] {
		OP_TICK      = 3'd0,
		OP_REGISTER  = 3'd1,
		OP_PERIOD    = 3'd2,
		OP_STARTUP   = 3'd3,
		OP_INTERRUPT = 3'd4
	} op_t;

	// Controls broadcast from the sequencer to every cell during a walk.
	typedef struct packed {
		logic                 mode_pend;
		logic [SLOT_BITS-1:0] pend_slot;
		logic                 out_free;
	} ctl_t;

	// Write strobe for the non-tick operations.
	typedef struct packed {
		logic                 en;
		op_t                  op;
		logic [SLOT_BITS-1:0] slot;
	} wr_t;

	// Status returned from each cell.
	typedef struct packed {
		logic holds_tok;
		logic fire_req;
	} rpt_t;

endpackage

// ===== rtl/core/ptt_cell.sv =====
// One timer slot: due time, period, startup delay, registration and the walk token.
module ptt_cell import ptt_pkg::*; #(
	parameter int IDX       = 0,
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_in,
	output logic                 tok_out,
	input  ctl_t                 ctl,
	input  wr_t                  wr,
	input  logic [TIME_BITS-1:0] now,
	input  logic [TIME_BITS-1:0] val,
	output rpt_t                 rpt
);

	localparam logic [TIME_BITS-1:0] ALL_ONES = '1;

	logic                 tok_q;
	logic                 phase_q;
	logic                 reg_q;
	logic [TIME_BITS-1:0] next_due_q;
	logic [TIME_BITS-1:0] period_q;
	logic [TIME_BITS-1:0] startup_q;

	logic                 sel;
	logic                 acting;
	logic                 due;
	logic                 step_done;
	logic                 fire_req;
	logic [TIME_BITS-1:0] start_val;
	logic [TIME_BITS-1:0] adv;
	logic [TIME_BITS-1:0] adv_cl;

	always_comb begin
		sel       = wr.en && (32'(wr.slot) == IDX);
		acting    = ctl.mode_pend ? (32'(ctl.pend_slot) == IDX) : reg_q;
		start_val = now + startup_q;
		due       = next_due_q <= now;
		adv       = (period_q == ALL_ONES) ? ALL_ONES : next_due_q + period_q;
		adv_cl    = (adv < now) ? now : adv;
		fire_req  = tok_q && acting && phase_q && due;
		// hand the token on once this slot is checked, or at once if it sits out
		step_done = tok_q && (!acting || (phase_q && (!due || ctl.out_free)));
	end

	assign tok_out       = step_done;
	assign rpt.holds_tok = tok_q;
	assign rpt.fire_req  = fire_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q      <= 1'b0;
			phase_q    <= 1'b0;
			reg_q      <= 1'b0;
			next_due_q <= '0;
			period_q   <= ALL_ONES;
			startup_q  <= '0;
		end else begin
			tok_q <= tok_in || (tok_q && !step_done);
			if (sel) begin
				unique case (wr.op)
					OP_REGISTER: reg_q <= 1'b1;
					OP_PERIOD: begin
						period_q   <= val;
						next_due_q <= now + val;
					end
					OP_STARTUP:   startup_q  <= val;
					OP_INTERRUPT: next_due_q <= now;
					default: ;
				endcase
			end else if (tok_q && acting && !phase_q) begin
				// start the check, and give a slot with no due time yet its first one
				phase_q <= 1'b1;
				if (next_due_q == '0) begin
					next_due_q <= start_val;
				end
			end else if (step_done) begin
				phase_q <= 1'b0;
				if (fire_req) begin
					next_due_q <= adv_cl;
				end
			end
		end
	end

endmodule

// ===== rtl/core/periodic_task_timer_bank.sv =====
// Periodic task timer bank: command sequencer, chain of slot cells and firing output.
//
//  channel | handshake             | payload
//  cmd     | cmd_valid / cmd_ready | operation, slot, value, now_ms
//  evt     | evt_valid / evt_ready | fired_slot, by_interrupt, last
//
// Register, period, startup and interrupt commands are written to their slot when accepted.
// A tick sends a token down the cell chain, highest slot first: a launch register
// starts it, each skipped cell passes it on and each checked cell holds it for a start
// and a check step. A pending interrupt adds one more such pass, with its own launch,
// ahead of the walk. A tick that fired ends in the flush state, which sends the last
// firing. A firing is held back so the final one can carry last; a full output
// register stalls the token in the firing cell. Reset clears all slot state.
module periodic_task_timer_bank import ptt_pkg::*; #(
	parameter int SLOT_COUNT = 8,
	parameter int TIME_BITS  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic [OP_BITS-1:0]   operation,
	input  logic [SLOT_BITS-1:0] slot,
	input  logic [31:0]          value,
	input  logic [31:0]          now_ms,
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output logic [SLOT_BITS-1:0] fired_slot,
	output logic                 by_interrupt,
	output logic                 last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FLUSH
	} state_t;

	state_t               state_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 mode_pend_q;
	logic                 pend_valid_q;
	logic [SLOT_BITS-1:0] pend_slot_q;
	logic                 launch_q;
	logic                 hold_valid_q;
	logic [SLOT_BITS-1:0] hold_slot_q;
	logic                 hold_intr_q;
	logic                 evt_valid_q;
	logic [SLOT_BITS-1:0] fired_slot_q;
	logic                 by_interrupt_q;
	logic                 last_q;

	logic [SLOT_COUNT:0]   tok_chain;
	logic [SLOT_COUNT-1:0] fire_vec;
	logic [SLOT_COUNT-1:0] tok_vec;
	rpt_t                  rpt [SLOT_COUNT];
	ctl_t                  ctl;
	wr_t                   wr;
	op_t                   op_in;
	logic                  accept;
	logic                  out_take;
	logic                  out_free;
	logic                  fire_go;
	logic                  end_pass;
	logic [SLOT_BITS-1:0]  fire_idx;
	logic [TIME_BITS-1:0]  now_bus;
	logic [TIME_BITS-1:0]  val_bus;

	assign op_in     = op_t'(operation);
	assign cmd_ready = (state_q == S_IDLE);
	assign accept    = cmd_valid && cmd_ready;
	assign out_take  = !evt_valid_q || evt_ready;
	assign out_free  = !hold_valid_q || out_take;
	assign end_pass  = tok_chain[0];
	assign now_bus   = (state_q == S_IDLE) ? TIME_BITS'(now_ms) : now_q;
	assign val_bus   = TIME_BITS'(value);

	assign tok_chain[SLOT_COUNT] = launch_q;

	assign ctl.mode_pend = mode_pend_q;
	assign ctl.pend_slot = pend_slot_q;
	assign ctl.out_free  = out_free;

	assign wr.en   = accept && (op_in != OP_TICK);
	assign wr.op   = op_in;
	assign wr.slot = slot;

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		ptt_cell #(
			.IDX       (g),
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_chain[g+1]),
			.tok_out (tok_chain[g]),
			.ctl     (ctl),
			.wr      (wr),
			.now     (now_bus),
			.val     (val_bus),
			.rpt     (rpt[g])
		);
		assign fire_vec[g] = rpt[g].fire_req;
		assign tok_vec[g]  = rpt[g].holds_tok;
	end

	always_comb begin
		fire_idx = '0;
		for (int k = 0; k < SLOT_COUNT; k++) begin
			if (fire_vec[k]) begin
				fire_idx = fire_idx | SLOT_BITS'(k);
			end
		end
	end

	assign fire_go = (|fire_vec) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			now_q          <= '0;
			mode_pend_q    <= 1'b0;
			pend_valid_q   <= 1'b0;
			pend_slot_q    <= '0;
			launch_q       <= 1'b0;
			hold_valid_q   <= 1'b0;
			hold_slot_q    <= '0;
			hold_intr_q    <= 1'b0;
			evt_valid_q    <= 1'b0;
			fired_slot_q   <= '0;
			by_interrupt_q <= 1'b0;
			last_q         <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			if (evt_valid_q && evt_ready) begin
				evt_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (op_in == OP_TICK) begin
							now_q        <= TIME_BITS'(now_ms);
							mode_pend_q  <= pend_valid_q;
							pend_valid_q <= 1'b0;
							launch_q     <= 1'b1;
							state_q      <= S_WALK;
						end else if (op_in == OP_INTERRUPT && 32'(slot) < SLOT_COUNT) begin
							pend_valid_q <= 1'b1;
							pend_slot_q  <= slot;
						end
					end
				end
				S_WALK: begin
					if (fire_go) begin
						// push the previous firing out, hold the new one
						if (hold_valid_q) begin
							evt_valid_q    <= 1'b1;
							fired_slot_q   <= hold_slot_q;
							by_interrupt_q <= hold_intr_q;
							last_q         <= 1'b0;
						end
						hold_valid_q <= 1'b1;
						hold_slot_q  <= fire_idx;
						hold_intr_q  <= mode_pend_q;
					end
					if (end_pass) begin
						if (mode_pend_q) begin
							mode_pend_q <= 1'b0;
							launch_q    <= 1'b1;
						end else begin
							state_q <= (hold_valid_q || fire_go) ? S_FLUSH : S_IDLE;
						end
					end
				end
				S_FLUSH: begin
					if (out_take) begin
						evt_valid_q    <= 1'b1;
						fired_slot_q   <= hold_slot_q;
						by_interrupt_q <= hold_intr_q;
						last_q         <= 1'b1;
						hold_valid_q   <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign evt_valid    = evt_valid_q;
	assign fired_slot   = fired_slot_q;
	assign by_interrupt = by_interrupt_q;
	assign last         = last_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vec))
		else $error("walk token held by more than one cell");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready |-> (!hold_valid_q && tok_vec == '0 && !launch_q))
		else $error("idle with a firing held or a token in the chain");

	a_fire_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(|fire_vec) |-> (state_q == S_WALK))
		else $error("cell fires outside a walk");

	a_flush_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FLUSH) |-> hold_valid_q)
		else $error("flush with no firing held");

endmodule
